>>> src/ctc_pkg.sv
package ctc_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int MAX_KEY_DEF = 9;

	localparam int KEY_SLOTS = 9;
	localparam int KEY_W     = 4 * KEY_SLOTS;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 64;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_KLEN = 2'd1;
	localparam logic [1:0] REG_KORD = 2'd2;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	localparam logic [3:0]       KLEN_RST = 4'd9;
	localparam logic [KEY_W-1:0] KORD_RST = 36'h987654321;

	localparam logic [7:0] CHAR_A = 8'h61;

	typedef struct packed {
		logic             mode;
		logic [3:0]       key_length;
		logic [KEY_W-1:0] key_order;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       overflow;
	} out_t;

endpackage

>>> src/ctc_regs.sv
module ctc_regs
	import ctc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic             mode_q;
	logic [3:0]       klen_q;
	logic [KEY_W-1:0] kord_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
			klen_q <= KLEN_RST;
			kord_q <= KORD_RST;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				REG_MODE: mode_q <= pwdata[0];
				REG_KLEN: klen_q <= pwdata[3:0];
				REG_KORD: kord_q <= pwdata[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[4:3])
			REG_MODE: prdata = APB_DW'(mode_q);
			REG_KLEN: prdata = APB_DW'(klen_q);
			REG_KORD: prdata = APB_DW'(kord_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg.mode       = mode_q;
	assign cfg.key_length = klen_q;
	assign cfg.key_order  = kord_q;

endmodule

>>> src/ctc_store.sv
module ctc_store
	import ctc_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF,
	localparam int AW = $clog2(MAX_LEN)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [MAX_LEN];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/ctc_seq.sv
module ctc_seq
	import ctc_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int MAX_KEY = MAX_KEY_DEF,
	localparam int AW = $clog2(MAX_LEN)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_t           in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_t          out_data,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int SW = CW + 4;

	typedef enum logic [1:0] {S_LOAD, S_EMIT, S_OUT} state_t;

	state_t          state_q;
	logic [CW-1:0]   fill_q;
	logic [3:0]      col_q;
	logic [CW-1:0]   rows_q;
	logic            drop_q;
	logic [CW-1:0]   inner_q;
	logic [CW-1:0]   outer_q;
	logic            pad_q;
	logic [7:0]      pad_byte_q;
	logic            last_q;
	logic            ovf_q;

	logic [3:0]      keff;
	logic            dec;
	logic [3:0]      dig [KEY_SLOTS];
	logic [CW-1:0]   rows_d;
	logic [CW-1:0]   nrows;
	logic [CW-1:0]   inner_lim;
	logic [CW-1:0]   outer_lim;
	logic [3:0]      sel;
	logic [3:0]      enc_col;
	logic [3:0]      dec_pos;
	logic [CW-1:0]   mul_a;
	logic [CW-1:0]   mul_b;
	logic [CW-1:0]   add_c;
	logic [SW-1:0]   sum;
	logic            pad;
	logic [7:0]      pad_byte;
	logic            inner_end;
	logic            last_item;
	logic            empty;
	logic            store_ok;
	logic            in_fire;

	always_comb begin
		if (cfg.key_length == 4'd0) begin
			keff = 4'd1;
		end else if (cfg.key_length > 4'(MAX_KEY)) begin
			keff = 4'(MAX_KEY);
		end else begin
			keff = cfg.key_length;
		end
	end

	assign dec = (cfg.mode == MODE_DEC);

	always_comb begin
		for (int q = 0; q < KEY_SLOTS; q++) begin
			dig[q] = cfg.key_order[4*q +: 4];
		end
	end

	// a partial last row counts for encrypt only
	assign rows_d    = rows_q - CW'(col_q != 4'd0);
	assign nrows     = dec ? rows_d : rows_q;
	assign inner_lim = dec ? CW'(keff) : nrows;
	assign outer_lim = dec ? nrows : CW'(keff);
	assign sel       = dec ? inner_q[3:0] : outer_q[3:0];

	always_comb begin
		if (dig[sel] >= 4'd1 && dig[sel] <= keff) begin
			enc_col = dig[sel] - 4'd1;
		end else begin
			enc_col = 4'd0;
		end
	end

	// first key position holding column sel+1; scan down so the lowest wins
	always_comb begin
		dec_pos = 4'd0;
		for (int q = KEY_SLOTS - 1; q >= 0; q--) begin
			if (4'(q) < keff && dig[q] == sel + 4'd1) begin
				dec_pos = 4'(q);
			end
		end
	end

	// shared address unit: a * b + c
	assign mul_a = dec ? CW'(dec_pos) : inner_q;
	assign mul_b = dec ? nrows : CW'(keff);
	assign add_c = dec ? outer_q : CW'(enc_col);
	assign sum   = SW'(mul_a) * SW'(mul_b) + SW'(add_c);

	assign pad      = !dec && (sum >= SW'(fill_q));
	assign pad_byte = CHAR_A + 8'(sum - SW'(fill_q));

	assign inner_end = (inner_q == inner_lim - CW'(1));
	assign last_item = inner_end && (outer_q == outer_lim - CW'(1));
	assign empty     = dec && (rows_d == '0);

	// keep a byte only if its whole row fits in the store
	assign store_ok = (SW'(fill_q) - SW'(col_q) + SW'(keff)) <= SW'(MAX_LEN);

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign in_fire   = in_valid && in_ready;

	assign mem_we    = in_fire && store_ok;
	assign mem_waddr = fill_q[AW-1:0];
	assign mem_wdata = in_data.in_byte;
	assign mem_re    = (state_q == S_EMIT);
	assign mem_raddr = sum[AW-1:0];

	assign out_data.out_byte = pad_q ? pad_byte_q : mem_rdata;
	assign out_data.out_last = last_q;
	assign out_data.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			fill_q     <= '0;
			col_q      <= '0;
			rows_q     <= '0;
			drop_q     <= 1'b0;
			inner_q    <= '0;
			outer_q    <= '0;
			pad_q      <= 1'b0;
			pad_byte_q <= '0;
			last_q     <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (store_ok) begin
							fill_q <= fill_q + CW'(1);
							col_q  <= (col_q == keff - 4'd1) ? 4'd0 : col_q + 4'd1;
							rows_q <= rows_q + CW'(col_q == 4'd0);
						end else begin
							drop_q <= 1'b1;
						end
						if (in_data.in_last) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (empty) begin
						fill_q  <= '0;
						col_q   <= '0;
						rows_q  <= '0;
						drop_q  <= 1'b0;
						state_q <= S_LOAD;
					end else begin
						pad_q      <= pad;
						pad_byte_q <= pad_byte;
						last_q     <= last_item;
						ovf_q      <= drop_q;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (last_q) begin
							fill_q  <= '0;
							col_q   <= '0;
							rows_q  <= '0;
							drop_q  <= 1'b0;
							inner_q <= '0;
							outer_q <= '0;
							state_q <= S_LOAD;
						end else begin
							if (inner_end) begin
								inner_q <= '0;
								outer_q <= outer_q + CW'(1);
							end else begin
								inner_q <= inner_q + CW'(1);
							end
							state_q <= S_EMIT;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_LEN))
		else $error("fill count beyond store depth");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.in_last |=> !in_ready)
		else $error("last byte did not start readout");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.out_last |=> in_ready && fill_q == '0 && !drop_q)
		else $error("message state not cleared after final byte");

endmodule

>>> src/columnar_transposition_cipher_top.sv
// Columnar transposition cipher over one message of up to MAX_LEN bytes. Bytes are loaded
// one per cycle while in_ready is high; the byte with in_last closes the message and the
// block then stops taking input and streams the result: encrypt pads to whole rows with
// 'a','b',... and reads column by column in key order, decrypt keeps whole rows only and
// reads row by row. For each output byte the block first forms its store address in the
// shared multiply-add unit and reads the message store, then presents the byte and holds
// it through any output stall. A decrypt with less than one whole row gives no output and
// goes straight back to loading. Bytes beyond the largest multiple of key_length (held
// to 1..MAX_KEY) that fits in the store are dropped and flagged on every output byte.
// Registers (APB, 64-bit data): mode at 0x00, key_length at 0x08, key_order at 0x10; change
// them only between messages. The key must be a permutation of 1..key_length.
module columnar_transposition_cipher_top
	import ctc_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int MAX_KEY = MAX_KEY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data
);

	localparam int AW = $clog2(MAX_LEN);

	cfg_t          cfg;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	ctc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctc_store #(
		.MAX_LEN (MAX_LEN)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ctc_seq #(
		.MAX_LEN (MAX_LEN),
		.MAX_KEY (MAX_KEY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

>>> tb/sv/columnar_transposition_cipher_top_tb.sv
`timescale 1ns / 1ps

module columnar_transposition_cipher_top_tb
	import ctc_pkg::*;
;

	localparam int STORE_DEPTH = 64;
	localparam int KEY_MAX     = 9;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_t               in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_t              out_data;

	// shadow of the block's registers and message store
	cfg_t       cfg_now;
	logic [7:0] msg_store [0:STORE_DEPTH-1];
	int         msg_fill;
	logic       msg_dropped;

	in_t  byte_q[$];
	out_t cipher_out_q[$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_cnt;

	columnar_transposition_cipher_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_cols(logic [3:0] klen);
		int k;
		k = klen;
		if (k == 0) k = 1;
		if (k > KEY_MAX) k = KEY_MAX;
		return k;
	endfunction

	// store one byte; on the closing byte emit the whole transformed message
	function automatic void cipher_absorb(in_t it);
		int         k, cap, n, rows, col, idx, p, i, j, q;
		logic [3:0] d;
		logic       found;
		out_t       r;
		out_t       msg_q[$];
		k   = eff_cols(cfg_now.key_length);
		cap = (STORE_DEPTH / k) * k;
		if (msg_fill < cap) begin
			msg_store[msg_fill] = it.in_byte;
			msg_fill++;
		end else begin
			msg_dropped = 1'b1;
		end
		if (!it.in_last) return;
		n = msg_fill;
		r.out_last = 1'b0;
		r.overflow = msg_dropped;
		if (cfg_now.mode == MODE_ENC) begin
			rows = (n + k - 1) / k;
			for (i = 0; i < k; i++) begin
				d   = cfg_now.key_order[4*i +: 4];
				col = (d >= 1 && d <= k) ? d - 1 : 0;
				for (j = 0; j < rows; j++) begin
					idx = j * k + col;
					r.out_byte = (idx < n) ? msg_store[idx] : CHAR_A + 8'(idx - n);
					msg_q = {msg_q, r};
				end
			end
		end else begin
			rows = n / k;
			for (j = 0; j < rows; j++) begin
				for (i = 0; i < k; i++) begin
					p = 0;
					found = 1'b0;
					for (q = 0; q < k; q++) begin
						if (!found && cfg_now.key_order[4*q +: 4] == i + 1) begin
							p = q;
							found = 1'b1;
						end
					end
					r.out_byte = msg_store[p * rows + j];
					msg_q = {msg_q, r};
				end
			end
		end
		if (msg_q.size() > 0) msg_q[msg_q.size()-1].out_last = 1'b1;
		cipher_out_q = {cipher_out_q, msg_q};
		msg_fill    = 0;
		msg_dropped = 1'b0;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) cipher_absorb(in_data);
			if (!in_valid || in_ready) begin
				if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= byte_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (cipher_out_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: expected no byte, got %02h last %b ovf %b", $time,
						out_data.out_byte, out_data.out_last, out_data.overflow);
				end else begin
					out_t want;
					want = cipher_out_q.pop_front();
					if (out_data !== want) begin
						mismatch_cnt++;
						$display("%0t: expected byte %02h last %b ovf %b, got %02h %b %b",
							$time, want.out_byte, want.out_last, want.overflow,
							out_data.out_byte, out_data.out_last, out_data.overflow);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic apb_write(input logic [1:0] reg_idx, input logic [APB_DW-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_idx)
			REG_MODE: cfg_now.mode       = val[0];
			REG_KLEN: cfg_now.key_length = val[3:0];
			REG_KORD: cfg_now.key_order  = val[KEY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_setup(input logic m, input logic [3:0] klen,
			input logic [KEY_W-1:0] kord);
		apb_write(REG_MODE, APB_DW'(m));
		apb_write(REG_KLEN, APB_DW'(klen));
		apb_write(REG_KORD, APB_DW'(kord));
	endtask

	// permutation of 1..k in the low digits, random digits above
	function automatic logic [KEY_W-1:0] shuffled_key(int k);
		int               digs [KEY_MAX];
		int               i, j, t;
		logic [KEY_W-1:0] key;
		key = {4'($urandom_range(0, 15)), 32'($urandom())};
		for (i = 0; i < k; i++) digs[i] = i + 1;
		for (i = k - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = digs[i];
			digs[i] = digs[j];
			digs[j] = t;
		end
		for (i = 0; i < k; i++) key[4*i +: 4] = 4'(digs[i]);
		return key;
	endfunction

	task automatic push_item(input logic [7:0] b, input logic l);
		in_t it;
		it.in_byte = b;
		it.in_last = l;
		byte_q = {byte_q, it};
	endtask

	task automatic queue_messages(input int budget);
		int k, cap, len, used, i;
		k    = eff_cols(cfg_now.key_length);
		cap  = (STORE_DEPTH / k) * k;
		used = 0;
		while (used < budget) begin
			case ($urandom_range(9))
				0:       len = $urandom_range(cap, cap + 4);
				1:       len = $urandom_range(1, k);
				default: len = $urandom_range(1, 3 * k + 2);
			endcase
			for (i = 0; i < len; i++) push_item(8'($urandom_range(0, 255)), i == len - 1);
			used += len;
		end
	endtask

	// wait until every request is taken and every result has come, then hold off
	task automatic drain();
		while (byte_q.size() > 0 || in_valid || cipher_out_q.size() > 0) @(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		int i, ph, k;
		cfg_now       = '{mode: MODE_ENC, key_length: KLEN_RST, key_order: KORD_RST};
		msg_fill      = 0;
		msg_dropped   = 1'b0;
		mismatch_cnt  = 0;
		send_idle_pct = 32;
		recv_idle_pct = 85;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single byte padded out, one exact row, two rows with padding
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'h7F, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(8'hAA, 1'b0);
		push_item(8'h55, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFE, 1'b0);
		push_item(8'h5A, 1'b1);
		for (i = 0; i < 10; i++) push_item(8'h30 + 8'(i), i == 9);
		drain();
		// decrypt shorter than one row gives nothing
		apb_write(REG_MODE, APB_DW'(MODE_DEC));
		for (i = 0; i < 4; i++) push_item(8'($urandom_range(0, 255)), i == 3);
		drain();

		for (ph = 0; ph < 14; ph++) begin
			if (ph == 5) begin
				send_idle_pct = 85;
				recv_idle_pct = 32;
			end else if (ph == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (ph)
				0:  load_setup(MODE_ENC, 4'd1, shuffled_key(1));
				1:  load_setup(MODE_DEC, 4'd1, shuffled_key(1));
				2:  load_setup(MODE_ENC, 4'd9, shuffled_key(9));
				3:  load_setup(MODE_DEC, 4'd9, shuffled_key(9));
				4:  load_setup(MODE_ENC, 4'd2, shuffled_key(2));
				5: begin
					k = $urandom_range(2, 8);
					load_setup(MODE_DEC, 4'(k), shuffled_key(k));
				end
				6: begin
					k = $urandom_range(3, 8);
					load_setup(MODE_ENC, 4'(k), shuffled_key(k));
				end
				7:  load_setup(MODE_DEC, 4'd0, shuffled_key(1));
				8:  load_setup(MODE_ENC, 4'd15, shuffled_key(9));
				9:  load_setup(MODE_DEC, 4'd12, shuffled_key(9));
				// broken keys: repeated, missing and out-of-range digits
				10: load_setup(MODE_DEC, 4'($urandom_range(1, 9)),
					{4'($urandom_range(0, 15)), 32'($urandom())});
				11: load_setup(MODE_ENC, 4'($urandom_range(1, 9)), {KEY_W{1'b1}});
				default: begin
					k = $urandom_range(1, 9);
					load_setup(logic'(ph & 1), 4'(k), shuffled_key(k));
				end
			endcase
			queue_messages(12);
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && cipher_out_q.size() == 0) begin
			$display("[columnar_transposition_cipher_top] OK");
		end else begin
			$display("[columnar_transposition_cipher_top] ERROR");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[columnar_transposition_cipher_top] ERROR");
		$finish;
	end

endmodule

>>> sim.f
src/ctc_pkg.sv
src/ctc_regs.sv
src/ctc_store.sv
src/ctc_seq.sv
src/columnar_transposition_cipher_top.sv
tb/sv/columnar_transposition_cipher_top_tb.sv
